### hdl/indexed_timer_min_heap_top_defines.svh
// Assertion macros for the timer heap RTL.
`ifndef INDEXED_TIMER_MIN_HEAP_TOP_DEFINES_SVH
`define INDEXED_TIMER_MIN_HEAP_TOP_DEFINES_SVH

`ifndef ASSERT_OFF
`define ITMH_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define ITMH_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define ITMH_ASSERT(lbl, prop, msg)
`define ITMH_NEVER(lbl, cond, msg)
`endif

`endif

### hdl/itmh_pkg.sv
`timescale 1ns / 1ps

package itmh_pkg;

  localparam int HEAP_DEPTH = 256;
  localparam int ID_COUNT   = 256;
  localparam int TIME_BITS  = 32;

  localparam int SLOT_W = $clog2(HEAP_DEPTH);
  localparam int CNT_W  = $clog2(HEAP_DEPTH + 1);
  localparam int ID_W   = $clog2(ID_COUNT);

  localparam logic [2:0] ACT_PUSH   = 3'd0;
  localparam logic [2:0] ACT_ADJUST = 3'd1;
  localparam logic [2:0] ACT_REMOVE = 3'd2;
  localparam logic [2:0] ACT_POP    = 3'd3;
  localparam logic [2:0] ACT_CLEAR  = 3'd4;

  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_ABSENT = 2'd1;
  localparam logic [1:0] ST_EMPTY  = 2'd2;
  localparam logic [1:0] ST_FULL   = 2'd3;

  typedef struct packed {
    logic [TIME_BITS-1:0] when;
    logic [ID_W-1:0]      id;
  } slot_t;

  localparam int SLOT_BITS = $bits(slot_t);

  typedef enum logic [3:0] {
    S_IDLE,
    S_ADJ_RD,
    S_ADJ_LD,
    S_DROP_RD,
    S_DROP_LD,
    S_SD_RD,
    S_SD_CMP,
    S_RU_RD,
    S_RU_CMP,
    S_WB,
    S_TOP_RD,
    S_RESULT
  } state_t;

endpackage

### hdl/indexed_timer_min_heap_top.sv
// Indexed binary min-heap of up to 256 timers ordered by expiry time. Each
// input transfer carries one command (push or update, adjust, remove, pop,
// clear) and produces exactly one result transfer with a status code, the
// number of timers held and the earliest timer. The heap lives in a slot
// RAM with two read ports and the id-to-slot map in a second RAM; a present
// bit per id lives in flip-flops, so reset and clear take effect at once
// with no sweep. Commands are handled one at a time. Clear, unused actions
// and every error go straight to the root read and the result. The other
// commands do the id-to-slot lookup where a held timer is named, then walk
// the heap level by level in the sift sequencer (a RAM read state and a
// compare-and-write state per level), then the final write-back where a
// timer moved, the root read and the result, which waits for a free output
// register.
// The next command is taken as soon as the result is loaded into the output
// register, even if that result has not yet been transferred.
`timescale 1ns / 1ps
`include "indexed_timer_min_heap_top_defines.svh"

module indexed_timer_min_heap_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // [7:0] timer_id, [39:8] expire_time
  input  logic [39:0] in_tdata,
  // [2:0] action
  input  logic [2:0]  in_tuser,
  output logic        out_tvalid,
  input  logic        out_tready,
  // [8:0] entry_count, [9] top_valid, [17:10] top_id, [49:18] top_expire
  output logic [55:0] out_tdata,
  // [1:0] status
  output logic [1:0]  out_tuser
);

  localparam int SW = itmh_pkg::SLOT_W;
  localparam int CW = itmh_pkg::CNT_W;
  localparam int IW = itmh_pkg::ID_W;
  localparam int TB = itmh_pkg::TIME_BITS;

  itmh_pkg::state_t state_r, state_nxt;

  logic [2:0]                act_r, act_nxt;
  logic [IW-1:0]             id_r, id_nxt;
  logic [TB-1:0]             when_r, when_nxt;
  logic [1:0]                status_r, status_nxt;
  logic [CW-1:0]             cnt_r, cnt_nxt;
  logic [itmh_pkg::ID_COUNT-1:0] present_r, present_nxt;
  itmh_pkg::slot_t           cur_r, cur_nxt;
  logic [SW-1:0]             pos_r, pos_nxt;
  logic                      moved_r, moved_nxt;

  logic                      out_tvalid_r, out_tvalid_nxt;
  logic [1:0]                out_status_r, out_status_nxt;
  logic [55:0]               out_data_r, out_data_nxt;

  // Heap slot RAM ports.
  logic                      heap_we;
  logic [SW-1:0]             heap_waddr, heap_raddr_a, heap_raddr_b;
  itmh_pkg::slot_t           heap_wdata, heap_rd_a, heap_rd_b;

  // Id-to-slot RAM.
  logic [SW-1:0]             pmem [itmh_pkg::ID_COUNT];
  logic                      pmem_we;
  logic [IW-1:0]             pmem_waddr, pmem_raddr;
  logic [SW-1:0]             pmem_wdata, pmem_rd_r;

  logic                      in_xfer;
  logic [IW-1:0]             in_id;
  logic [TB-1:0]             in_when;
  logic                      in_held;
  logic [SW+1:0]             kid, kid_r1;
  logic                      has_kid, has_right, take_right, sd_stop, ru_stop;
  itmh_pkg::slot_t           sel;
  logic [SW+1:0]             sel_pos;
  logic [SW-1:0]             up_pos;
  logic [CW-1:0]             cnt_last;
  logic [SW-1:0]             drop_pos;
  logic [IW-1:0]             drop_id;
  logic                      drop_moves;
  logic                      out_free;

  assign in_tready  = (state_r == itmh_pkg::S_IDLE);
  assign in_xfer    = in_tvalid && in_tready;
  assign in_id      = in_tdata[IW-1:0];
  assign in_when    = in_tdata[8 +: TB];
  assign in_held    = present_r[in_id];
  assign out_free   = !out_tvalid_r || out_tready;

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_status_r;

  // Children of the current slot, and its parent.
  assign kid        = {1'b0, pos_r, 1'b1};
  assign kid_r1     = kid + (SW+2)'(1);
  assign has_kid    = kid < (SW+2)'(cnt_r);
  assign has_right  = kid_r1 < (SW+2)'(cnt_r);
  assign take_right = has_right && (heap_rd_b.when < heap_rd_a.when);
  assign sel        = take_right ? heap_rd_b : heap_rd_a;
  assign sel_pos    = take_right ? kid_r1 : kid;
  assign sd_stop    = cur_r.when < sel.when;
  assign up_pos     = SW'((pos_r - SW'(1)) >> 1);
  assign ru_stop    = heap_rd_a.when < cur_r.when;

  // Removal: the last slot fills the vacated one.
  assign cnt_last   = cnt_r - CW'(1);
  assign drop_pos   = (act_r == itmh_pkg::ACT_POP) ? '0 : pmem_rd_r;
  assign drop_id    = (act_r == itmh_pkg::ACT_POP) ? heap_rd_b.id : id_r;
  assign drop_moves = CW'(drop_pos) < cnt_last;

  itmh_ram2r #(
    .WIDTH (itmh_pkg::SLOT_BITS),
    .DEPTH (itmh_pkg::HEAP_DEPTH)
  ) u_heap (
    .clk     (clk),
    .we      (heap_we),
    .waddr   (heap_waddr),
    .wdata   (heap_wdata),
    .raddr_a (heap_raddr_a),
    .raddr_b (heap_raddr_b),
    .rdata_a (heap_rd_a),
    .rdata_b (heap_rd_b)
  );

  always_ff @(posedge clk) begin
    if (pmem_we) begin
      pmem[pmem_waddr] <= pmem_wdata;
    end
    pmem_rd_r <= pmem[pmem_raddr];
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      itmh_pkg::S_IDLE: begin
        if (in_xfer) begin
          case (in_tuser)
            itmh_pkg::ACT_PUSH: begin
              if (in_held) begin
                state_nxt = itmh_pkg::S_ADJ_RD;
              end else if (cnt_r == CW'(itmh_pkg::HEAP_DEPTH)) begin
                state_nxt = itmh_pkg::S_TOP_RD;
              end else begin
                state_nxt = itmh_pkg::S_RU_RD;
              end
            end
            itmh_pkg::ACT_ADJUST: begin
              state_nxt = in_held ? itmh_pkg::S_ADJ_RD : itmh_pkg::S_TOP_RD;
            end
            itmh_pkg::ACT_REMOVE: begin
              state_nxt = in_held ? itmh_pkg::S_DROP_RD : itmh_pkg::S_TOP_RD;
            end
            itmh_pkg::ACT_POP: begin
              state_nxt = (cnt_r == '0) ? itmh_pkg::S_TOP_RD : itmh_pkg::S_DROP_RD;
            end
            default: begin
              state_nxt = itmh_pkg::S_TOP_RD;
            end
          endcase
        end
      end
      itmh_pkg::S_ADJ_RD:  state_nxt = itmh_pkg::S_ADJ_LD;
      itmh_pkg::S_ADJ_LD:  state_nxt = itmh_pkg::S_SD_RD;
      itmh_pkg::S_DROP_RD: state_nxt = itmh_pkg::S_DROP_LD;
      itmh_pkg::S_DROP_LD: begin
        state_nxt = drop_moves ? itmh_pkg::S_SD_RD : itmh_pkg::S_TOP_RD;
      end
      itmh_pkg::S_SD_RD: begin
        if (has_kid) begin
          state_nxt = itmh_pkg::S_SD_CMP;
        end else begin
          state_nxt = moved_r ? itmh_pkg::S_WB : itmh_pkg::S_RU_RD;
        end
      end
      itmh_pkg::S_SD_CMP: begin
        if (sd_stop) begin
          state_nxt = moved_r ? itmh_pkg::S_WB : itmh_pkg::S_RU_RD;
        end else begin
          state_nxt = itmh_pkg::S_SD_RD;
        end
      end
      itmh_pkg::S_RU_RD: begin
        state_nxt = (pos_r == '0) ? itmh_pkg::S_WB : itmh_pkg::S_RU_CMP;
      end
      itmh_pkg::S_RU_CMP: begin
        state_nxt = ru_stop ? itmh_pkg::S_WB : itmh_pkg::S_RU_RD;
      end
      itmh_pkg::S_WB:     state_nxt = itmh_pkg::S_TOP_RD;
      itmh_pkg::S_TOP_RD: state_nxt = itmh_pkg::S_RESULT;
      itmh_pkg::S_RESULT: begin
        if (out_free) begin
          state_nxt = itmh_pkg::S_IDLE;
        end
      end
      default: state_nxt = itmh_pkg::S_IDLE;
    endcase
  end

  // Datapath and memory control.
  always_comb begin
    act_nxt        = act_r;
    id_nxt         = id_r;
    when_nxt       = when_r;
    status_nxt     = status_r;
    cnt_nxt        = cnt_r;
    present_nxt    = present_r;
    cur_nxt        = cur_r;
    pos_nxt        = pos_r;
    moved_nxt      = moved_r;
    out_tvalid_nxt = out_tvalid_r && !out_tready;
    out_status_nxt = out_status_r;
    out_data_nxt   = out_data_r;
    heap_we        = 1'b0;
    heap_waddr     = pos_r;
    heap_wdata     = cur_r;
    heap_raddr_a   = '0;
    heap_raddr_b   = '0;
    pmem_we        = 1'b0;
    pmem_waddr     = cur_r.id;
    pmem_wdata     = pos_r;
    pmem_raddr     = id_r;

    case (state_r)
      itmh_pkg::S_IDLE: begin
        if (in_xfer) begin
          act_nxt    = in_tuser;
          id_nxt     = in_id;
          when_nxt   = in_when;
          status_nxt = itmh_pkg::ST_OK;
          case (in_tuser)
            itmh_pkg::ACT_PUSH: begin
              if (!in_held) begin
                if (cnt_r == CW'(itmh_pkg::HEAP_DEPTH)) begin
                  status_nxt = itmh_pkg::ST_FULL;
                end else begin
                  cur_nxt.id          = in_id;
                  cur_nxt.when        = in_when;
                  pos_nxt             = cnt_r[SW-1:0];
                  cnt_nxt             = cnt_r + CW'(1);
                  present_nxt[in_id]  = 1'b1;
                end
              end
            end
            itmh_pkg::ACT_ADJUST, itmh_pkg::ACT_REMOVE: begin
              if (!in_held) begin
                status_nxt = itmh_pkg::ST_ABSENT;
              end
            end
            itmh_pkg::ACT_POP: begin
              if (cnt_r == '0) begin
                status_nxt = itmh_pkg::ST_EMPTY;
              end
            end
            itmh_pkg::ACT_CLEAR: begin
              present_nxt = '0;
              cnt_nxt     = '0;
            end
            default: begin
            end
          endcase
        end
      end
      itmh_pkg::S_ADJ_RD: begin
        pmem_raddr = id_r;
      end
      itmh_pkg::S_ADJ_LD: begin
        cur_nxt.id   = id_r;
        cur_nxt.when = when_r;
        pos_nxt      = pmem_rd_r;
        moved_nxt    = 1'b0;
      end
      itmh_pkg::S_DROP_RD: begin
        pmem_raddr   = id_r;
        heap_raddr_a = cnt_last[SW-1:0];
        heap_raddr_b = '0;
      end
      itmh_pkg::S_DROP_LD: begin
        present_nxt[drop_id] = 1'b0;
        cnt_nxt              = cnt_last;
        cur_nxt              = heap_rd_a;
        pos_nxt              = drop_pos;
        moved_nxt            = 1'b0;
      end
      itmh_pkg::S_SD_RD: begin
        heap_raddr_a = kid[SW-1:0];
        heap_raddr_b = kid_r1[SW-1:0];
      end
      itmh_pkg::S_SD_CMP: begin
        if (!sd_stop) begin
          heap_we    = 1'b1;
          heap_waddr = pos_r;
          heap_wdata = sel;
          pmem_we    = 1'b1;
          pmem_waddr = sel.id;
          pmem_wdata = pos_r;
          pos_nxt    = sel_pos[SW-1:0];
          moved_nxt  = 1'b1;
        end
      end
      itmh_pkg::S_RU_RD: begin
        heap_raddr_a = up_pos;
      end
      itmh_pkg::S_RU_CMP: begin
        if (!ru_stop) begin
          heap_we    = 1'b1;
          heap_waddr = pos_r;
          heap_wdata = heap_rd_a;
          pmem_we    = 1'b1;
          pmem_waddr = heap_rd_a.id;
          pmem_wdata = pos_r;
          pos_nxt    = up_pos;
        end
      end
      itmh_pkg::S_WB: begin
        heap_we    = 1'b1;
        heap_waddr = pos_r;
        heap_wdata = cur_r;
        pmem_we    = 1'b1;
        pmem_waddr = cur_r.id;
        pmem_wdata = pos_r;
      end
      itmh_pkg::S_TOP_RD: begin
        heap_raddr_a = '0;
      end
      itmh_pkg::S_RESULT: begin
        if (out_free) begin
          out_tvalid_nxt = 1'b1;
          out_status_nxt = status_r;
          out_data_nxt   = '0;
          out_data_nxt[8:0] = 9'(cnt_r);
          if (cnt_r != '0) begin
            out_data_nxt[9]     = 1'b1;
            out_data_nxt[17:10] = 8'(heap_rd_a.id);
            out_data_nxt[49:18] = 32'(heap_rd_a.when);
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= itmh_pkg::S_IDLE;
      cnt_r        <= '0;
      present_r    <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      cnt_r        <= cnt_nxt;
      present_r    <= present_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    act_r        <= act_nxt;
    id_r         <= id_nxt;
    when_r       <= when_nxt;
    status_r     <= status_nxt;
    cur_r        <= cur_nxt;
    pos_r        <= pos_nxt;
    moved_r      <= moved_nxt;
    out_status_r <= out_status_nxt;
    out_data_r   <= out_data_nxt;
  end

  `ITMH_NEVER(a_cnt_bound, cnt_r > CW'(itmh_pkg::HEAP_DEPTH), "held count above heap depth")
  `ITMH_ASSERT(a_busy_after_xfer, in_xfer |=> (state_r != itmh_pkg::S_IDLE), "idle after transfer")
  `ITMH_ASSERT(a_kid_in_heap, (state_r == itmh_pkg::S_SD_CMP) |-> has_kid, "child beyond count")
  `ITMH_ASSERT(a_write_in_heap, heap_we |-> (CW'(heap_waddr) < cnt_r), "slot write beyond count")

endmodule

### hdl/itmh_ram2r.sv
`timescale 1ns / 1ps

// Synchronous RAM, one write port and two registered read ports.
module itmh_ram2r #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr_a,
  input  logic [AW-1:0]    raddr_b,
  output logic [WIDTH-1:0] rdata_a,
  output logic [WIDTH-1:0] rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

### verif/tb.sv
`timescale 1ns / 1ps

module tb;

  typedef struct packed {
    logic [2:0]  action;
    logic [7:0]  timer_id;
    logic [31:0] expire_time;
  } cmd_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [8:0]  entry_count;
    logic        top_valid;
    logic [7:0]  top_id;
    logic [31:0] top_expire;
  } heap_result_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [39:0] in_tdata;
  logic [2:0]  in_tuser;
  logic        out_tvalid;
  logic        out_tready;
  logic [55:0] out_tdata;
  logic [1:0]  out_tuser;

  indexed_timer_min_heap_top dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready),
    .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready),
    .out_tdata(out_tdata), .out_tuser(out_tuser)
  );

  // Shadow copy of the heap used to predict every result.
  logic [7:0]  shadow_id [itmh_pkg::HEAP_DEPTH];
  logic [31:0] shadow_when [itmh_pkg::HEAP_DEPTH];
  bit          id_held [itmh_pkg::ID_COUNT];
  int          slot_of [itmh_pkg::ID_COUNT];
  int          held_count = 0;

  cmd_t         pending_cmds[$];
  heap_result_t expected_results[$];
  int           error_count = 0;

  bit quiet_phase;      // no idling near the end
  bit sender_hold;      // sender pauses for the drain
  bit long_stall_req;   // asks for the long receiver stall
  bit long_stall;       // receiver long stall in progress

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #40_000_000;
    $display("Verification failed");
    $finish;
  end

  // The long receiver stall is counted here, apart from the receiver.
  initial begin
    long_stall = 1'b0;
    wait (long_stall_req);
    long_stall = 1'b1;
    repeat (400) @(posedge clk);
    long_stall = 1'b0;
  end

  function automatic void swap_slots(int a, int b);
    logic [7:0]  tid;
    logic [31:0] tw;
    tid = shadow_id[a]; tw = shadow_when[a];
    shadow_id[a] = shadow_id[b]; shadow_when[a] = shadow_when[b];
    shadow_id[b] = tid; shadow_when[b] = tw;
    slot_of[shadow_id[a]] = a;
    slot_of[shadow_id[b]] = b;
  endfunction

  function automatic void sift_up(int pos);
    int parent;
    while (pos > 0) begin
      parent = (pos - 1) / 2;
      if (shadow_when[parent] < shadow_when[pos]) break;
      swap_slots(pos, parent);
      pos = parent;
    end
  endfunction

  function automatic bit sift_down(int pos, int lim);
    int start;
    int kid;
    start = pos;
    kid = pos * 2 + 1;
    while (kid < lim) begin
      if (kid + 1 < lim && shadow_when[kid + 1] < shadow_when[kid]) kid++;
      if (shadow_when[pos] < shadow_when[kid]) break;
      swap_slots(pos, kid);
      pos = kid;
      kid = pos * 2 + 1;
    end
    return pos > start;
  endfunction

  function automatic void rekey(int pos);
    if (!sift_down(pos, held_count)) sift_up(pos);
  endfunction

  function automatic void drop_slot(int pos);
    int last;
    last = held_count - 1;
    if (pos < last) begin
      swap_slots(pos, last);
      if (!sift_down(pos, last)) sift_up(pos);
    end
    id_held[shadow_id[last]] = 1'b0;
    held_count = last;
  endfunction

  // Applies one command to the shadow heap and returns the result it causes.
  function automatic heap_result_t apply_timer_cmd(cmd_t c);
    heap_result_t r;
    int p;
    r = '0;
    r.status = itmh_pkg::ST_OK;
    case (c.action)
      itmh_pkg::ACT_PUSH: begin
        if (id_held[c.timer_id]) begin
          p = slot_of[c.timer_id];
          shadow_when[p] = c.expire_time;
          rekey(p);
        end else if (held_count >= itmh_pkg::HEAP_DEPTH) begin
          r.status = itmh_pkg::ST_FULL;
        end else begin
          p = held_count;
          shadow_id[p] = c.timer_id;
          shadow_when[p] = c.expire_time;
          slot_of[c.timer_id] = p;
          id_held[c.timer_id] = 1'b1;
          held_count++;
          sift_up(p);
        end
      end
      itmh_pkg::ACT_ADJUST: begin
        if (!id_held[c.timer_id]) begin
          r.status = itmh_pkg::ST_ABSENT;
        end else begin
          p = slot_of[c.timer_id];
          shadow_when[p] = c.expire_time;
          rekey(p);
        end
      end
      itmh_pkg::ACT_REMOVE: begin
        if (!id_held[c.timer_id]) r.status = itmh_pkg::ST_ABSENT;
        else drop_slot(slot_of[c.timer_id]);
      end
      itmh_pkg::ACT_POP: begin
        if (held_count == 0) r.status = itmh_pkg::ST_EMPTY;
        else drop_slot(0);
      end
      itmh_pkg::ACT_CLEAR: begin
        foreach (id_held[k]) id_held[k] = 1'b0;
        held_count = 0;
      end
      default: ;
    endcase
    r.entry_count = held_count[8:0];
    if (held_count > 0) begin
      r.top_valid = 1'b1;
      r.top_id = shadow_id[0];
      r.top_expire = shadow_when[0];
    end
    return r;
  endfunction

  function automatic cmd_t make_cmd(logic [2:0] a, logic [7:0] id, logic [31:0] t);
    cmd_t c;
    c.action = a;
    c.timer_id = id;
    c.expire_time = t;
    return c;
  endfunction

  function automatic void queue_cmd(cmd_t c);
    pending_cmds.insert(pending_cmds.size(), c);
  endfunction

  function automatic logic [31:0] rand_expiry();
    // Narrow ranges force many equal keys, which exercise the tie rules.
    case ($urandom_range(0, 3))
      0: return $urandom_range(0, 15);
      1: return 32'hFFFF_FFF0 | $urandom_range(0, 15);
      default: return $urandom;
    endcase
  endfunction

  // Random command mix; the id range is narrowed at times so that
  // adjust and remove mostly find a held timer.
  function automatic cmd_t rand_cmd(int id_span, int push_weight);
    logic [7:0] id;
    int sel;
    id = 8'($urandom_range(0, id_span));
    sel = $urandom_range(0, 99);
    if (sel < push_weight) return make_cmd(itmh_pkg::ACT_PUSH, id, rand_expiry());
    if (sel < push_weight + 15) return make_cmd(itmh_pkg::ACT_ADJUST, id, rand_expiry());
    if (sel < push_weight + 27) return make_cmd(itmh_pkg::ACT_REMOVE, id, rand_expiry());
    if (sel < push_weight + 37) return make_cmd(itmh_pkg::ACT_POP, id, $urandom);
    if (sel < push_weight + 39) return make_cmd(itmh_pkg::ACT_CLEAR, 8'($urandom), $urandom);
    return make_cmd(3'(5 + $urandom_range(0, 2)), 8'($urandom), $urandom);
  endfunction

  // Driver: pops the next pending command and holds it until transferred.
  int sender_gap;
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      in_tdata <= '0;
      in_tuser <= '0;
      sender_gap <= 0;
    end else if (!in_tvalid || in_tready) begin
      if (sender_gap > 0) begin
        in_tvalid <= 1'b0;
        sender_gap <= sender_gap - 1;
      end else if (sender_hold || pending_cmds.size() == 0) begin
        in_tvalid <= 1'b0;
      end else if (!quiet_phase && $urandom_range(0, 9) == 0) begin
        in_tvalid <= 1'b0;
        sender_gap <= $urandom_range(0, 12);
      end else begin
        cmd_t c;
        c = pending_cmds.pop_front();
        expected_results.insert(expected_results.size(), apply_timer_cmd(c));
        in_tvalid <= 1'b1;
        in_tdata <= {c.expire_time, c.timer_id};
        in_tuser <= c.action;
      end
    end
  end

  // Receiver: random stalls plus one long hold-off on request.
  int receiver_gap;
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
      receiver_gap <= 0;
    end else if (long_stall) begin
      out_tready <= 1'b0;
    end else if (receiver_gap > 0) begin
      out_tready <= 1'b0;
      receiver_gap <= receiver_gap - 1;
    end else if (!quiet_phase && $urandom_range(0, 9) == 0) begin
      out_tready <= 1'b0;
      receiver_gap <= $urandom_range(0, 12);
    end else begin
      out_tready <= 1'b1;
    end
  end

  // Monitor: compares each transferred result with the oldest expectation.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      heap_result_t got;
      heap_result_t want;
      got = '{status: out_tuser, entry_count: out_tdata[8:0], top_valid: out_tdata[9],
              top_id: out_tdata[17:10], top_expire: out_tdata[49:18]};
      if (expected_results.size() == 0) begin
        $display("%0t: result expected none actual status=%0d count=%0d", $time,
                 got.status, got.entry_count);
        error_count++;
      end else begin
        want = expected_results.pop_front();
        if (got.status !== want.status) begin
          $display("%0t: status expected %0d actual %0d", $time, want.status, got.status);
          error_count++;
        end
        if (got.entry_count !== want.entry_count) begin
          $display("%0t: entry_count expected %0d actual %0d", $time, want.entry_count,
                   got.entry_count);
          error_count++;
        end
        if (got.top_valid !== want.top_valid) begin
          $display("%0t: top_valid expected %0d actual %0d", $time, want.top_valid,
                   got.top_valid);
          error_count++;
        end
        if (got.top_id !== want.top_id) begin
          $display("%0t: top_id expected %0d actual %0d", $time, want.top_id, got.top_id);
          error_count++;
        end
        if (got.top_expire !== want.top_expire) begin
          $display("%0t: top_expire expected %h actual %h", $time, want.top_expire,
                   got.top_expire);
          error_count++;
        end
      end
    end
  end

  task automatic wait_drained();
    while (pending_cmds.size() != 0 || expected_results.size() != 0 || in_tvalid)
      @(posedge clk);
  endtask

  initial begin
    int n;
    rst_n = 1'b0;
    quiet_phase = 1'b0;
    sender_hold = 1'b0;
    long_stall_req = 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: empty-heap errors, extremes of the fields, ties, every action.
    queue_cmd(make_cmd(itmh_pkg::ACT_POP, 8'd0, 32'd0));
    queue_cmd(make_cmd(itmh_pkg::ACT_ADJUST, 8'd255, 32'd1));
    queue_cmd(make_cmd(itmh_pkg::ACT_REMOVE, 8'd0, 32'd0));
    queue_cmd(make_cmd(itmh_pkg::ACT_PUSH, 8'd255, 32'hFFFF_FFFF));
    queue_cmd(make_cmd(itmh_pkg::ACT_PUSH, 8'd0, 32'd0));
    queue_cmd(make_cmd(itmh_pkg::ACT_PUSH, 8'd17, 32'd0));
    queue_cmd(make_cmd(itmh_pkg::ACT_PUSH, 8'd170, 32'h5555_5555));
    queue_cmd(make_cmd(itmh_pkg::ACT_PUSH, 8'd85, 32'hAAAA_AAAA));
    queue_cmd(make_cmd(itmh_pkg::ACT_PUSH, 8'd0, 32'hFFFF_FFFF));
    queue_cmd(make_cmd(itmh_pkg::ACT_ADJUST, 8'd255, 32'd0));
    queue_cmd(make_cmd(itmh_pkg::ACT_ADJUST, 8'd17, 32'h8000_0000));
    queue_cmd(make_cmd(itmh_pkg::ACT_REMOVE, 8'd170, 32'd0));
    queue_cmd(make_cmd(itmh_pkg::ACT_REMOVE, 8'd170, 32'd0));
    queue_cmd(make_cmd(3'd5, 8'd1, 32'd1));
    queue_cmd(make_cmd(3'd6, 8'd2, 32'd2));
    queue_cmd(make_cmd(3'd7, 8'hFF, 32'hFFFF_FFFF));
    queue_cmd(make_cmd(itmh_pkg::ACT_POP, 8'd0, 32'd0));
    queue_cmd(make_cmd(itmh_pkg::ACT_CLEAR, 8'd0, 32'd0));
    queue_cmd(make_cmd(itmh_pkg::ACT_POP, 8'd0, 32'd0));
    queue_cmd(make_cmd(itmh_pkg::ACT_PUSH, 8'd9, 32'd7));
    wait_drained();

    // Fill to full, clear, fill again with every id, update by push and by adjust while full, then pop.
    for (int k = 0; k < itmh_pkg::HEAP_DEPTH; k++)
      queue_cmd(make_cmd(itmh_pkg::ACT_PUSH, k[7:0], rand_expiry()));
    queue_cmd(make_cmd(itmh_pkg::ACT_CLEAR, 8'd0, 32'd0));
    for (int k = 0; k < itmh_pkg::HEAP_DEPTH; k++)
      queue_cmd(make_cmd(itmh_pkg::ACT_PUSH, 8'(255 - k), rand_expiry()));
    queue_cmd(make_cmd(itmh_pkg::ACT_PUSH, 8'd3, 32'd0));
    queue_cmd(make_cmd(itmh_pkg::ACT_ADJUST, 8'd200, 32'hFFFF_FFFF));
    // Long receiver hold-off while the sender keeps offering.
    long_stall_req = 1'b1;
    for (int k = 0; k < 60; k++)
      queue_cmd(make_cmd(itmh_pkg::ACT_POP, 8'd0, 32'd0));
    wait_drained();

    // Sender pauses for a full drain between random phases.
    n = 0;
    while (n < 960) begin
      queue_cmd(rand_cmd((n / 200) % 2 ? 255 : 31, (n / 300) % 2 ? 40 : 55));
      n++;
      if (n % 400 == 0) begin
        while (pending_cmds.size() != 0) @(posedge clk);
        sender_hold = 1'b1;
        while (expected_results.size() != 0) @(posedge clk);
        sender_hold = 1'b0;
      end
    end
    wait_drained();

    quiet_phase = 1'b1;
    for (int k = 0; k < 200; k++) queue_cmd(rand_cmd(63, 45));
    wait_drained();
    repeat (50) @(posedge clk);

    if (error_count == 0 && expected_results.size() == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule

### files.f
+incdir+hdl
hdl/itmh_pkg.sv
hdl/itmh_ram2r.sv
hdl/indexed_timer_min_heap_top.sv
verif/tb.sv
